[hdl/rpa_pkg.sv]
package rpa_pkg;

  // Width of the shared add/subtract unit: 32-bit addresses plus one bit for carries
  localparam int unsigned ALU_W = 33;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_END = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHYS_TOP   = 1'b1;

  localparam logic [31:0] KERNEL_END_RST = 32'h8000_0000;
  localparam logic [31:0] PHYS_TOP_RST   = 32'h8800_0000;

  localparam logic [1:0] OP_INIT   = 2'd0;
  localparam logic [1:0] OP_ALLOC  = 2'd1;
  localparam logic [1:0] OP_ADDREF = 2'd2;
  localparam logic [1:0] OP_FREE   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_BADADDR  = 3'd2;
  localparam logic [2:0] ST_ZERO     = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  typedef struct packed {
    logic             sub;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] page_addr;
    logic [7:0]  ref_count;
  } res_t;

endpackage

[hdl/rpa_alu.sv]
module rpa_alu (
  input  rpa_pkg::alu_req_t          req,
  output logic [rpa_pkg::ALU_W:0]    res
);

  // Top bit is the carry on add and the borrow on subtract
  always_comb begin
    if (req.sub) begin
      res = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      res = {1'b0, req.a} + {1'b0, req.b};
    end
  end

endmodule

[hdl/rpa_ctrl.sv]
module rpa_ctrl #(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_op,
  input  logic [31:0]                 in_addr,
  input  logic [31:0]                 kernel_end,
  input  logic [31:0]                 phys_top,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rpa_pkg::res_t               res,
  output rpa_pkg::alu_req_t           alu_req,
  input  logic [rpa_pkg::ALU_W:0]     alu_res
);

  localparam int unsigned IDX_W  = $clog2(MAX_PAGES);
  localparam int unsigned TOP_W  = $clog2(MAX_PAGES + 1);
  localparam int unsigned PG_SH  = $clog2(PAGE_BYTES);
  localparam int unsigned PGC_W  = rpa_pkg::ALU_W - PG_SH;
  localparam int unsigned OFF_W  = IDX_W + PG_SH;
  localparam int unsigned WIDE_W = rpa_pkg::ALU_W + 1;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_BASE    = 4'd1;
  localparam logic [3:0] S_INIT_N  = 4'd2;
  localparam logic [3:0] S_SWEEP   = 4'd3;
  localparam logic [3:0] S_A_POP   = 4'd4;
  localparam logic [3:0] S_A_IDX   = 4'd5;
  localparam logic [3:0] S_A_CNT   = 4'd6;
  localparam logic [3:0] S_CHK_LO  = 4'd7;
  localparam logic [3:0] S_CHK_HI  = 4'd8;
  localparam logic [3:0] S_CHK_IDX = 4'd9;
  localparam logic [3:0] S_UPD     = 4'd10;
  localparam logic [3:0] S_RESP    = 4'd11;

  logic [3:0]                  state_r, state_nxt;
  logic                        resp_r, resp_nxt;
  logic [TOP_W-1:0]            n_r, n_nxt;
  logic [IDX_W-1:0]            i_r, i_nxt;
  logic [TOP_W-1:0]            top_r, top_nxt;

  logic [1:0]                  op_r, op_nxt;
  logic [31:0]                 addr_r, addr_nxt;
  logic [rpa_pkg::ALU_W-1:0]   base_r, base_nxt;
  logic                        lo_bad_r, lo_bad_nxt;
  logic                        hi_ok_r, hi_ok_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  rpa_pkg::res_t               res_r, res_nxt;

  logic [PGC_W-1:0]            pg_cnt;
  logic [OFF_W-1:0]            pg_off;
  logic                        addr_bad;

  logic [7:0]                  ref_mem [MAX_PAGES];
  logic [7:0]                  ref_q;
  logic                        ref_we;
  logic [IDX_W-1:0]            ref_wa, ref_ra;
  logic [7:0]                  ref_wd;

  logic [IDX_W-1:0]            stk_mem [MAX_PAGES];
  logic [IDX_W-1:0]            stk_q;
  logic                        stk_we;
  logic [IDX_W-1:0]            stk_wa, stk_ra, stk_wd;

  assign pg_cnt = alu_res[rpa_pkg::ALU_W-1:PG_SH];
  assign pg_off = {idx_r, {PG_SH{1'b0}}};
  assign addr_bad = (addr_r[PG_SH-1:0] != '0) || lo_bad_r || !hi_ok_r ||
                    (WIDE_W'(pg_cnt) >= WIDE_W'(MAX_PAGES));

  assign in_ready = (state_r == S_IDLE);
  assign res      = res_r;

  always_comb begin
    state_nxt  = state_r;
    resp_nxt   = resp_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    top_nxt    = top_r;
    op_nxt     = op_r;
    addr_nxt   = addr_r;
    base_nxt   = base_r;
    lo_bad_nxt = lo_bad_r;
    hi_ok_nxt  = hi_ok_r;
    idx_nxt    = idx_r;
    res_nxt    = res_r;
    alu_req.sub = 1'b0;
    alu_req.a   = '0;
    alu_req.b   = '0;
    ref_we = 1'b0;
    ref_wa = '0;
    ref_wd = '0;
    ref_ra = '0;
    stk_we = 1'b0;
    stk_wa = '0;
    stk_wd = '0;
    stk_ra = '0;
    res_valid = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_op;
          addr_nxt  = in_addr;
          res_nxt   = '0;
          state_nxt = S_BASE;
        end
      end
      S_BASE: begin
        // round kernel_end up to a page boundary
        alu_req.a = {1'b0, kernel_end};
        alu_req.b = rpa_pkg::ALU_W'(PAGE_BYTES - 1);
        base_nxt  = {alu_res[rpa_pkg::ALU_W-1:PG_SH], {PG_SH{1'b0}}};
        case (op_r)
          rpa_pkg::OP_INIT:  state_nxt = S_INIT_N;
          rpa_pkg::OP_ALLOC: state_nxt = S_A_POP;
          default:           state_nxt = S_CHK_LO;
        endcase
      end
      S_INIT_N: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, phys_top};
        alu_req.b   = base_r;
        if (alu_res[rpa_pkg::ALU_W]) begin
          n_nxt = '0;
        end else if (WIDE_W'(pg_cnt) > WIDE_W'(MAX_PAGES)) begin
          n_nxt = TOP_W'(MAX_PAGES);
        end else begin
          n_nxt = TOP_W'(pg_cnt);
        end
        i_nxt     = '0;
        resp_nxt  = 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        // zero one count per cycle, push the page while below the page count
        ref_we = 1'b1;
        ref_wa = i_r;
        if (TOP_W'(i_r) < n_r) begin
          stk_we = 1'b1;
          stk_wa = i_r;
          stk_wd = i_r;
        end
        if (i_r == IDX_W'(MAX_PAGES - 1)) begin
          top_nxt   = n_r;
          state_nxt = resp_r ? S_RESP : S_IDLE;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      S_A_POP: begin
        if (top_r == '0) begin
          res_nxt.status = rpa_pkg::ST_EMPTY;
          state_nxt      = S_RESP;
        end else begin
          stk_ra    = IDX_W'(top_r - 1'b1);
          state_nxt = S_A_IDX;
        end
      end
      S_A_IDX: begin
        idx_nxt   = stk_q;
        ref_ra    = stk_q;
        state_nxt = S_A_CNT;
      end
      S_A_CNT: begin
        if (ref_q != 8'd0) begin
          res_nxt.status    = rpa_pkg::ST_BUSY;
          res_nxt.ref_count = ref_q;
        end else begin
          ref_we    = 1'b1;
          ref_wa    = idx_r;
          ref_wd    = 8'd1;
          top_nxt   = top_r - 1'b1;
          alu_req.a = base_r;
          alu_req.b = rpa_pkg::ALU_W'(pg_off);
          res_nxt.status    = rpa_pkg::ST_OK;
          res_nxt.page_addr = alu_res[31:0];
          res_nxt.ref_count = 8'd1;
        end
        state_nxt = S_RESP;
      end
      S_CHK_LO: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, addr_r};
        alu_req.b   = {1'b0, kernel_end};
        lo_bad_nxt  = alu_res[rpa_pkg::ALU_W];
        state_nxt   = S_CHK_HI;
      end
      S_CHK_HI: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, addr_r};
        alu_req.b   = {1'b0, phys_top};
        hi_ok_nxt   = alu_res[rpa_pkg::ALU_W];
        state_nxt   = S_CHK_IDX;
      end
      S_CHK_IDX: begin
        alu_req.sub = 1'b1;
        alu_req.a   = {1'b0, addr_r};
        alu_req.b   = base_r;
        if (addr_bad) begin
          res_nxt.status = rpa_pkg::ST_BADADDR;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt   = IDX_W'(pg_cnt);
          ref_ra    = IDX_W'(pg_cnt);
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (ref_q == 8'd0) begin
          res_nxt.status = rpa_pkg::ST_ZERO;
        end else if (op_r == rpa_pkg::OP_ADDREF && ref_q == 8'hFF) begin
          res_nxt.status    = rpa_pkg::ST_OVERFLOW;
          res_nxt.ref_count = ref_q;
        end else begin
          alu_req.sub = (op_r == rpa_pkg::OP_FREE);
          alu_req.a   = rpa_pkg::ALU_W'(ref_q);
          alu_req.b   = rpa_pkg::ALU_W'(1);
          ref_we = 1'b1;
          ref_wa = idx_r;
          ref_wd = alu_res[7:0];
          res_nxt.ref_count = alu_res[7:0];
          // last reference gone: push the page back unless the stack is full
          if (op_r == rpa_pkg::OP_FREE && alu_res[7:0] == 8'd0 &&
              top_r != TOP_W'(MAX_PAGES)) begin
            stk_we  = 1'b1;
            stk_wa  = IDX_W'(top_r);
            stk_wd  = idx_r;
            top_nxt = top_r + 1'b1;
          end
        end
        state_nxt = S_RESP;
      end
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // reset runs the zeroing sweep with no pages and no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
      resp_r  <= 1'b0;
      n_r     <= '0;
      i_r     <= '0;
      top_r   <= '0;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
      n_r     <= n_nxt;
      i_r     <= i_nxt;
      top_r   <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    addr_r   <= addr_nxt;
    base_r   <= base_nxt;
    lo_bad_r <= lo_bad_nxt;
    hi_ok_r  <= hi_ok_nxt;
    idx_r    <= idx_nxt;
    res_r    <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[ref_wa] <= ref_wd;
    end
    ref_q <= ref_mem[ref_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_q <= stk_mem[stk_ra];
  end

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= TOP_W'(MAX_PAGES))
    else $error("free stack pointer past capacity");

  a_alloc_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r == S_A_CNT && ref_q == 8'd0) |=> top_r == $past(top_r) - 1'b1)
    else $error("successful alloc did not pop the free stack");

  a_alloc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && op_r == rpa_pkg::OP_ALLOC && res_r.status == rpa_pkg::ST_OK)
      |-> res_r.ref_count == 8'd1)
    else $error("allocated page does not report a count of one");

  a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && state_r == S_SWEEP && i_r == IDX_W'(MAX_PAGES - 1)) |=> top_r == $past(n_r))
    else $error("stack depth after sweep differs from page count");

endmodule

[hdl/refcounted_page_allocator.sv]
// Channel  Handshake              Payload
// in       in_valid / in_ready    in_op[1:0], in_addr[31:0]
// out      out_valid / out_ready  out_status[2:0], out_page_addr[31:0], out_ref_count[7:0]
// cfg      cfg_valid / cfg_ready  cfg_index[0], cfg_data[31:0]
//
// Per op, after rounding the base: alloc reads the free stack top and sets its count (out of
// pages, it stops at the pop); add reference and free check bounds, then update if valid.
// One add/subtract unit serves every rounding, bound check and address computation,
// one step per cycle; the count and free stack memories each give one read a cycle.
// Init sweeps every count too; after reset a sweep zeroes the counts; in_ready stays low.
// The result register holds while out_ready is low; a new item is taken meanwhile.
module refcounted_page_allocator #(
  parameter int unsigned MAX_PAGES  = 32768,
  parameter int unsigned PAGE_BYTES = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_op,
  input  logic [31:0]                       in_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [31:0]                       out_page_addr,
  output logic [7:0]                        out_ref_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [31:0]                 kernel_end_r;
  logic [31:0]                 phys_top_r;
  logic                        out_valid_r;
  rpa_pkg::res_t               out_res_r;

  logic                        res_valid;
  logic                        res_ready;
  rpa_pkg::res_t               res;
  rpa_pkg::alu_req_t           alu_req;
  logic [rpa_pkg::ALU_W:0]     alu_res;

  assign cfg_ready = 1'b1;
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_end_r <= rpa_pkg::KERNEL_END_RST;
      phys_top_r   <= rpa_pkg::PHYS_TOP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpa_pkg::CFG_KERNEL_END: kernel_end_r <= cfg_data;
        rpa_pkg::CFG_PHYS_TOP:   phys_top_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // output register: load when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_res_r.status;
  assign out_page_addr = out_res_r.page_addr;
  assign out_ref_count = out_res_r.ref_count;

  rpa_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  rpa_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_addr    (in_addr),
    .kernel_end (kernel_end_r),
    .phys_top   (phys_top_r),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .alu_req    (alu_req),
    .alu_res    (alu_res)
  );

endmodule
